>>> rtl/hkr_pkg.sv
// Shared types and constants for the hotkey event router queue.
// Depends on nothing; every other file of the block uses it.
package hkr_pkg;

	localparam int QDEPTH  = 64;
	localparam int PTR_W   = $clog2(QDEPTH);
	localparam int CNT_W   = $clog2(QDEPTH + 1);
	localparam int NUM_CTL = 7;
	localparam int KEY_W   = 10;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 11;

	localparam logic [15:0] EV_SYN          = 16'd0;
	localparam logic [15:0] EV_KEY          = 16'd1;
	localparam logic [15:0] SYN_LOST_EVENTS = 16'd3;
	localparam logic [15:0] KEY_NONE        = 16'd0;

	// Configuration register indices.
	localparam logic [CFG_AW-1:0] REG_TOGGLE  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_UP      = 3'd1;
	localparam logic [CFG_AW-1:0] REG_DOWN    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_LEFT    = 3'd3;
	localparam logic [CFG_AW-1:0] REG_RIGHT   = 3'd4;
	localparam logic [CFG_AW-1:0] REG_CONFIRM = 3'd5;
	localparam logic [CFG_AW-1:0] REG_ERASE   = 3'd6;
	localparam logic [CFG_AW-1:0] REG_CHARSET = 3'd7;

	typedef enum logic [1:0] {
		OP_EVENT      = 2'd0,
		OP_POP        = 2'd1,
		OP_CLEAR      = 2'd2,
		OP_SET_ACTIVE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		OC_FORWARDED    = 3'd0,
		OC_QUEUED       = 3'd1,
		OC_DROPPED_FULL = 3'd2,
		OC_DISCARDED    = 3'd3,
		OC_POPPED       = 3'd4,
		OC_EMPTY        = 3'd5,
		OC_DONE         = 3'd6
	} outcome_t;

	typedef struct packed {
		logic        overflow;
		logic        pressed;
		logic [15:0] keycode;
	} action_t;

	typedef struct packed {
		op_t                op;
		logic [15:0]        ev_type;
		logic [15:0]        ev_code;
		logic signed [31:0] ev_value;
		logic               new_active;
	} in_item_t;

	typedef struct packed {
		outcome_t           outcome;
		logic [15:0]        fwd_type;
		logic [15:0]        fwd_code;
		logic signed [31:0] fwd_value;
		logic [15:0]        act_keycode;
		logic               act_pressed;
		logic               act_sync_dropped;
		logic [CNT_W-1:0]   queue_count;
	} out_item_t;

	typedef struct packed {
		logic latch;
		logic commit;
		logic pop_issue;
		logic pop_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pop_hit;
	} dp_status_t;

endpackage

>>> rtl/hkr_if.sv
// Request channels of the hotkey event router queue: input, result and
// configuration write. Depends on hkr_pkg for widths.
interface hkr_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [15:0]        ev_type;
	logic [15:0]        ev_code;
	logic signed [31:0] ev_value;
	logic               new_active;

	modport source (output valid, op, ev_type, ev_code, ev_value, new_active, input ready);
	modport sink (input valid, op, ev_type, ev_code, ev_value, new_active, output ready);
endinterface

interface hkr_out_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  outcome;
	logic [15:0]                 fwd_type;
	logic [15:0]                 fwd_code;
	logic signed [31:0]          fwd_value;
	logic [15:0]                 act_keycode;
	logic                        act_pressed;
	logic                        act_sync_dropped;
	logic [hkr_pkg::CNT_W-1:0]   queue_count;

	modport source (output valid, outcome, fwd_type, fwd_code, fwd_value, act_keycode,
		act_pressed, act_sync_dropped, queue_count, input ready);
	modport sink (input valid, outcome, fwd_type, fwd_code, fwd_value, act_keycode,
		act_pressed, act_sync_dropped, queue_count, output ready);
endinterface

interface hkr_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [hkr_pkg::CFG_AW-1:0]  addr;
	logic [hkr_pkg::CFG_DW-1:0]  data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

>>> rtl/hotkey_event_router_queue.sv
// Hotkey event router queue: routes key events by capture mode into an
// action FIFO of 64 entries, or forwards or discards them.
// The result is registered at commit in the execute state or, for a pop with data,
// after the registered read of the action store in the read state.
// A new request is taken only when idle; a result not yet taken stalls execute and read.
// Reset clears configuration, capture mode, pointers and count; the store is not cleared.
module hotkey_event_router_queue (
	input logic      clk,
	input logic      arst_n,
	hkr_in_if.sink   item,
	hkr_out_if.source result,
	hkr_cfg_if.sink  cfg
);
	import hkr_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	in_item_t   item_in;
	out_item_t  res_out;

	assign cfg.ready = 1'b1;

	assign item_in.op         = op_t'(item.op);
	assign item_in.ev_type    = item.ev_type;
	assign item_in.ev_code    = item.ev_code;
	assign item_in.ev_value   = item.ev_value;
	assign item_in.new_active = item.new_active;

	hkr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	hkr_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.valid),
		.cfg_addr (cfg.addr),
		.cfg_data (cfg.data),
		.item_in  (item_in),
		.cmd      (cmd),
		.status   (status),
		.res_out  (res_out)
	);

	assign result.outcome          = res_out.outcome;
	assign result.fwd_type         = res_out.fwd_type;
	assign result.fwd_code         = res_out.fwd_code;
	assign result.fwd_value        = res_out.fwd_value;
	assign result.act_keycode      = res_out.act_keycode;
	assign result.act_pressed      = res_out.act_pressed;
	assign result.act_sync_dropped = res_out.act_sync_dropped;
	assign result.queue_count      = res_out.queue_count;

endmodule

>>> rtl/hkr_ctrl.sv
// Controller of the hotkey event router queue: sequences each request
// through execute and, for a pop with data, a memory read. Depends on hkr_pkg.
module hkr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  hkr_pkg::dp_status_t status,
	output hkr_pkg::ctrl_cmd_t  cmd
);
	import hkr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.latch     = in_valid && (state_q == ST_IDLE);
		case (state_q)
			ST_EXEC: begin
				// A pop with data must first read the store; it needs no output slot yet.
				if (status.pop_hit)
					cmd.pop_issue = 1'b1;
				else
					cmd.commit = out_free;
			end
			ST_READ: begin
				cmd.pop_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (cmd.latch) state_q <= ST_EXEC;
				ST_EXEC: begin
					if (cmd.pop_issue)
						state_q <= ST_READ;
					else if (cmd.commit)
						state_q <= ST_IDLE;
				end
				ST_READ: if (cmd.pop_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit || cmd.pop_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_read_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> ($past(cmd.pop_issue) || $past(state_q) == ST_READ))
		else $error("read state entered without a store read");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> (state_q == ST_EXEC && !in_ready))
		else $error("accepted request not executed next cycle");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("waiting result withdrawn before it was taken");

endmodule

>>> rtl/hkr_datapath.sv
// Datapath of the hotkey event router queue: configuration registers,
// event classification, action store with pointers, result register.
// Depends on hkr_pkg.
module hkr_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hkr_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [hkr_pkg::CFG_DW-1:0] cfg_data,
	input  hkr_pkg::in_item_t          item_in,
	input  hkr_pkg::ctrl_cmd_t         cmd,
	output hkr_pkg::dp_status_t        status,
	output hkr_pkg::out_item_t         res_out
);
	import hkr_pkg::*;

	logic signed [CFG_DW-1:0] toggle_code_q;
	logic [KEY_W-1:0]         ctl_keys_q [NUM_CTL];
	logic                     capture_active_q;
	logic [PTR_W-1:0]         rd_ptr_q;
	logic [PTR_W-1:0]         wr_ptr_q;
	logic [CNT_W-1:0]         count_q;
	action_t                  store [QDEPTH];
	action_t                  rdata_q;
	in_item_t                 item_q;
	out_item_t                res_q;

	logic      toggle_hit;
	logic      ctl_hit;
	logic      is_drop;
	logic      key_ok;
	logic      full;
	logic      want_push;
	logic      push_en;
	logic      fwd_en;
	action_t   push_entry;
	outcome_t  ev_outcome;
	out_item_t commit_res;
	out_item_t pop_res;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_code_q <= '1;
			for (int i = 0; i < NUM_CTL; i++)
				ctl_keys_q[i] <= '0;
		end else if (cfg_we) begin
			if (cfg_addr == REG_TOGGLE)
				toggle_code_q <= cfg_data;
			else
				ctl_keys_q[cfg_addr - REG_UP] <= cfg_data[KEY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch)
			item_q <= item_in;
	end

	// Event classification. A negative toggle key matches no code.
	always_comb begin
		toggle_hit = !toggle_code_q[CFG_DW-1] &&
			(16'(toggle_code_q[KEY_W-1:0]) == item_q.ev_code);
		ctl_hit = toggle_hit;
		for (int i = 0; i < NUM_CTL; i++)
			if (16'(ctl_keys_q[i]) == item_q.ev_code)
				ctl_hit = 1'b1;
		is_drop = (item_q.ev_type == EV_SYN) && (item_q.ev_code == SYN_LOST_EVENTS);
		// Of key events, only presses and releases are captured; the value is compared unsigned.
		key_ok  = (item_q.ev_type == EV_KEY) && (item_q.ev_value[31:1] == '0);
		full    = (count_q == CNT_W'(QDEPTH));

		want_push  = 1'b0;
		fwd_en     = 1'b0;
		ev_outcome = OC_DISCARDED;
		push_entry = '{overflow: 1'b0, pressed: item_q.ev_value[0],
			keycode: item_q.ev_code};
		if (capture_active_q) begin
			if (is_drop) begin
				want_push  = 1'b1;
				push_entry = '{overflow: 1'b1, pressed: 1'b0, keycode: KEY_NONE};
			end else if (ctl_hit && key_ok) begin
				want_push = 1'b1;
			end
		end else if (item_q.ev_type == EV_KEY && toggle_hit) begin
			want_push = key_ok;
		end else begin
			fwd_en     = 1'b1;
			ev_outcome = OC_FORWARDED;
		end
		if (want_push)
			ev_outcome = full ? OC_DROPPED_FULL : OC_QUEUED;
		push_en = cmd.commit && (item_q.op == OP_EVENT) && want_push && !full;
	end

	assign status.pop_hit = (item_q.op == OP_POP) && (count_q != '0);

	always_comb begin
		commit_res             = '0;
		commit_res.queue_count = count_q;
		case (item_q.op)
			OP_EVENT: begin
				commit_res.outcome = ev_outcome;
				if (fwd_en) begin
					commit_res.fwd_type  = item_q.ev_type;
					commit_res.fwd_code  = item_q.ev_code;
					commit_res.fwd_value = item_q.ev_value;
				end
				if (want_push && !full)
					commit_res.queue_count = count_q + 1'b1;
			end
			OP_POP: commit_res.outcome = OC_EMPTY;
			OP_CLEAR: begin
				commit_res.outcome     = OC_DONE;
				commit_res.queue_count = '0;
			end
			OP_SET_ACTIVE: commit_res.outcome = OC_DONE;
			default: ;
		endcase
	end

	// Pointers and count are already advanced when the read data is shown.
	always_comb begin
		pop_res                  = '0;
		pop_res.outcome          = OC_POPPED;
		pop_res.act_keycode      = rdata_q.keycode;
		pop_res.act_pressed      = rdata_q.pressed;
		pop_res.act_sync_dropped = rdata_q.overflow;
		pop_res.queue_count      = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_active_q <= 1'b0;
			rd_ptr_q         <= '0;
			wr_ptr_q         <= '0;
			count_q          <= '0;
		end else if (cmd.pop_issue) begin
			rd_ptr_q <= ptr_inc(rd_ptr_q);
			count_q  <= count_q - 1'b1;
		end else if (cmd.commit) begin
			case (item_q.op)
				OP_EVENT: begin
					if (push_en) begin
						wr_ptr_q <= ptr_inc(wr_ptr_q);
						count_q  <= count_q + 1'b1;
					end
				end
				OP_CLEAR: begin
					rd_ptr_q <= '0;
					wr_ptr_q <= '0;
					count_q  <= '0;
				end
				OP_SET_ACTIVE: capture_active_q <= item_q.new_active;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_en)
			store[wr_ptr_q] <= push_entry;
		if (cmd.pop_issue)
			rdata_q <= store[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit)
			res_q <= commit_res;
		else if (cmd.pop_load)
			res_q <= pop_res;
	end

	assign res_out = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QDEPTH))
		else $error("action count beyond queue depth");

	a_ptr_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q == PTR_W'(rd_ptr_q + count_q))
		else $error("write pointer out of step with read pointer and count");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_issue |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not reduce the action count");

endmodule
